// ===== hdl/mnps_pkg.sv =====
// Shared types and constants for the monophonic last-note-priority stack.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mnps_pkg;

  localparam int NOTE_W          = 7;
  localparam int BYTE_W          = 8;
  localparam int NOTE_COUNT      = 128;
  localparam int DEF_STACK_DEPTH = 128;

  localparam logic [BYTE_W-1:0] STATUS_MASK     = 8'hF0;
  localparam logic [BYTE_W-1:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [BYTE_W-1:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [NOTE_W-1:0] RESET_NOTE      = 7'd69;

  // Kind of message, decoded once when the beat is taken.
  typedef enum logic [1:0] {
    OP_IGNORE,
    OP_ON,
    OP_OFF
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TOPCHK,
    ST_POPCHK,
    ST_RESULT
  } state_t;

  // Access to the held-flag bank: one write and one read per cycle.
  typedef struct packed {
    logic              we;
    logic              value;
    logic [NOTE_W-1:0] wr_note;
    logic [NOTE_W-1:0] rd_note;
  } held_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/mnps_stack_mem.sv =====
// Note stack storage: one write port and one registered read port.
// Depends on mnps_pkg for the note width.
`default_nettype none

module mnps_stack_mem
  import mnps_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [NOTE_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [NOTE_W-1:0] rd_data
);

  logic [NOTE_W-1:0] mem [STACK_DEPTH];

  // Write, and read with the data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/mnps_held_flags.sv =====
// Held flag per MIDI note, cleared together at reset.
// Depends on mnps_pkg for the command struct and note count.
`default_nettype none

module mnps_held_flags
  import mnps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire held_cmd_t cmd,
  output logic           rd_bit
);

  logic [NOTE_COUNT-1:0] flags;

  // Set or clear one flag per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (cmd.we) begin
      flags[cmd.wr_note] <= cmd.value;
    end
  end

  // Look up the flag of the note read from the stack.
  assign rd_bit = flags[cmd.rd_note];

endmodule

`default_nettype wire

// ===== hdl/mnps_seq.sv =====
// Sequencer: decodes a message, pushes or walks down the stack one entry
// per cycle, and builds the result. Depends on mnps_pkg.
`default_nettype none

module mnps_seq
  import mnps_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [BYTE_W-1:0] status_byte,
  input  wire logic [BYTE_W-1:0] note_number,
  input  wire logic [BYTE_W-1:0] velocity,
  output logic                   busy,
  output logic                   done,
  output logic      [NOTE_W-1:0] current_note,
  output logic                   pitch_update,
  output logic                   gate_open,
  output logic                   gate_close,
  output logic                   stack_overflow,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_wr_addr,
  output logic      [NOTE_W-1:0] mem_wr_data,
  output logic      [AW-1:0]     mem_rd_addr,
  input  wire logic [NOTE_W-1:0] mem_rd_data,
  output held_cmd_t              held_cmd,
  input  wire logic              held_bit
);

  state_t            state, state_next;
  op_t               op, op_in;
  logic [NOTE_W-1:0] note;
  logic [CW-1:0]     count, count_next;
  logic [NOTE_W-1:0] playing, playing_next;
  logic              pitch, pitch_next;
  logic              gopen, gopen_next;
  logic              gclose, gclose_next;
  logic              ovf, ovf_next;
  logic              accept;
  logic              empty, last, full, top_match;

  assign accept    = start && (state == ST_IDLE);
  assign empty     = (count == '0);
  assign last      = (count == CW'(1));
  assign full      = (count == CW'(STACK_DEPTH));
  assign top_match = (mem_rd_data == note);

  // Message decode at the input beat.
  always_comb begin
    if (note_number[BYTE_W-1]) begin
      op_in = OP_IGNORE;
    end else if ((status_byte & STATUS_MASK) == STATUS_NOTE_ON && velocity != '0) begin
      op_in = OP_ON;
    end else if ((status_byte & STATUS_MASK) == STATUS_NOTE_ON
                 || (status_byte & STATUS_MASK) == STATUS_NOTE_OFF) begin
      op_in = OP_OFF;
    end else begin
      op_in = OP_IGNORE;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (op == OP_IGNORE || empty) state_next = ST_RESULT;
        else                          state_next = ST_TOPCHK;
      end
      ST_TOPCHK: begin
        if (op == OP_OFF && top_match && !last) state_next = ST_POPCHK;
        else                                    state_next = ST_RESULT;
      end
      ST_POPCHK: begin
        if (held_bit || last) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and port controls.
  always_comb begin
    count_next   = count;
    playing_next = playing;
    pitch_next   = pitch;
    gopen_next   = gopen;
    gclose_next  = gclose;
    ovf_next     = ovf;
    mem_we       = 1'b0;
    mem_wr_addr  = count[AW-1:0];
    mem_wr_data  = note;
    held_cmd.we      = 1'b0;
    held_cmd.value   = (op == OP_ON);
    held_cmd.wr_note = note;
    held_cmd.rd_note = mem_rd_data;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          pitch_next  = 1'b0;
          gopen_next  = 1'b0;
          gclose_next = 1'b0;
          ovf_next    = 1'b0;
        end
      end
      ST_DECODE: begin
        held_cmd.we = (op != OP_IGNORE);
        // A note-on into an empty stack pushes and opens the gate.
        if (op == OP_ON && empty) begin
          mem_we       = 1'b1;
          count_next   = count + CW'(1);
          playing_next = note;
          pitch_next   = 1'b1;
          gopen_next   = 1'b1;
        end
      end
      ST_TOPCHK: begin
        if (op == OP_ON) begin
          // Repeated top note is ignored; otherwise push or flag overflow.
          if (!top_match) begin
            if (full) begin
              ovf_next = 1'b1;
            end else begin
              mem_we       = 1'b1;
              count_next   = count + CW'(1);
              playing_next = note;
              pitch_next   = 1'b1;
            end
          end
        end else if (top_match) begin
          // Released note was on top: pop it.
          count_next = count - CW'(1);
          if (last) gclose_next = 1'b1;
        end
      end
      ST_POPCHK: begin
        // Play the first still-held entry, else pop past it.
        if (held_bit) begin
          playing_next = mem_rd_data;
          pitch_next   = 1'b1;
        end else begin
          count_next = count - CW'(1);
          if (last) gclose_next = 1'b1;
        end
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Always read the entry that will be on top next cycle.
  assign mem_rd_addr = AW'(count_next - CW'(1));

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      playing <= RESET_NOTE;
      pitch   <= 1'b0;
      gopen   <= 1'b0;
      gclose  <= 1'b0;
      ovf     <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      playing <= playing_next;
      pitch   <= pitch_next;
      gopen   <= gopen_next;
      gclose  <= gclose_next;
      ovf     <= ovf_next;
    end
  end

  // Message registers taken at the input beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= op_in;
      note <= note_number[NOTE_W-1:0];
    end
  end

  assign busy           = (state != ST_IDLE);
  assign done           = (state == ST_RESULT);
  assign current_note   = playing;
  assign pitch_update   = pitch;
  assign gate_open      = gopen;
  assign gate_close     = gclose;
  assign stack_overflow = ovf;

endmodule

`default_nettype wire

// ===== hdl/mono_note_priority_stack_top.sv =====
// Monophonic last-note-priority stack; one MIDI message per beat, one result each.
// Steps: an ignored message, or one on an empty stack, goes from decode straight to the result;
// any other message first checks the stack top, and a release of the top that leaves entries
// walks down the stack one popped entry at a time until a held note is found or the gate closes.
// busy holds through the done cycle, so the next beat follows done.
// No stalls on results. Synchronous reset clears held flags and stack count; note is 69.
`default_nettype none

module mono_note_priority_stack_top
  import mnps_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [BYTE_W-1:0] status_byte,
  input  wire logic [BYTE_W-1:0] note_number,
  input  wire logic [BYTE_W-1:0] velocity,
  output logic                   done,
  output logic      [NOTE_W-1:0] current_note,
  output logic                   pitch_update,
  output logic                   gate_open,
  output logic                   gate_close,
  output logic                   stack_overflow
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic              mem_we;
  logic [AW-1:0]     mem_wr_addr;
  logic [NOTE_W-1:0] mem_wr_data;
  logic [AW-1:0]     mem_rd_addr;
  logic [NOTE_W-1:0] mem_rd_data;
  held_cmd_t         held_cmd;
  logic              held_bit;

  // Sequencer.
  mnps_seq #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .status_byte    (status_byte),
    .note_number    (note_number),
    .velocity       (velocity),
    .busy           (busy),
    .done           (done),
    .current_note   (current_note),
    .pitch_update   (pitch_update),
    .gate_open      (gate_open),
    .gate_close     (gate_close),
    .stack_overflow (stack_overflow),
    .mem_we         (mem_we),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data),
    .held_cmd       (held_cmd),
    .held_bit       (held_bit)
  );

  // Note stack.
  mnps_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Held flags.
  mnps_held_flags u_held (
    .clk    (clk),
    .rst    (rst),
    .cmd    (held_cmd),
    .rd_bit (held_bit)
  );

endmodule

`default_nettype wire

// ===== sim/tb_mono_note_priority_stack_top.sv =====
// Self-checking testbench for the monophonic last-note-priority stack.
// Drives MIDI messages into mono_note_priority_stack_top, predicts each result
// in SystemVerilog and checks it; depends on mnps_pkg and the top module only.
`default_nettype none

module tb_mono_note_priority_stack_top;
  import mnps_pkg::*;

  localparam int NOTE_DEPTH    = DEF_STACK_DEPTH;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int DRAIN_CYCLES  = NOTE_DEPTH + 12;
  localparam int RANDOM_ITEMS  = 820;
  localparam int REPORT_LIMIT  = 10;

  // One predicted result, tagged with the message that caused it.
  typedef struct {
    logic [BYTE_W-1:0] msg_status;
    logic [BYTE_W-1:0] msg_note;
    logic [BYTE_W-1:0] msg_velo;
    logic [NOTE_W-1:0] note;
    logic              pitch;
    logic              gopen;
    logic              gclose;
    logic              ovf;
  } voice_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] note_number;
  logic [BYTE_W-1:0] velocity;
  logic              done;
  logic [NOTE_W-1:0] current_note;
  logic              pitch_update;
  logic              gate_open;
  logic              gate_close;
  logic              stack_overflow;

  // Predictor state: held flags, pressed-note stack and the sounding note.
  logic [NOTE_COUNT-1:0] held_mask;
  logic [NOTE_W-1:0]     press_stack [NOTE_DEPTH];
  int                    press_depth;
  logic [NOTE_W-1:0]     sounding_note;

  voice_result_t voice_due[$];
  voice_result_t voice_got;

  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned errors;
  int unsigned msgs_sent;
  int unsigned results_seen;
  int unsigned cnt_open, cnt_close, cnt_pitch, cnt_ovf;
  int          deepest;

  mono_note_priority_stack_top dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .status_byte    (status_byte),
    .note_number    (note_number),
    .velocity       (velocity),
    .done           (done),
    .current_note   (current_note),
    .pitch_update   (pitch_update),
    .gate_open      (gate_open),
    .gate_close     (gate_close),
    .stack_overflow (stack_overflow)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Voice allocation for one message: updates the predictor state and
  // returns the result the block should give for it.
  task automatic voice_predict(input logic [BYTE_W-1:0] st, input logic [BYTE_W-1:0] nt,
                               input logic [BYTE_W-1:0] vl, output voice_result_t r);
    op_t               op;
    logic [NOTE_W-1:0] n;
    r            = '{default: '0};
    r.msg_status = st;
    r.msg_note   = nt;
    r.msg_velo   = vl;
    n            = nt[NOTE_W-1:0];
    if (nt >= NOTE_COUNT)
      op = OP_IGNORE;
    else if ((st & STATUS_MASK) == STATUS_NOTE_ON && vl != 0)
      op = OP_ON;
    else if ((st & STATUS_MASK) == STATUS_NOTE_ON || (st & STATUS_MASK) == STATUS_NOTE_OFF)
      op = OP_OFF;
    else
      op = OP_IGNORE;

    case (op)
      OP_ON: begin
        held_mask[n] = 1'b1;
        if (press_depth > 0 && press_stack[press_depth-1] == n) begin
          // Same note already on top: only the held flag changes.
        end else if (press_depth >= NOTE_DEPTH) begin
          r.ovf = 1'b1;
        end else begin
          r.gopen                  = (press_depth == 0);
          sounding_note            = n;
          r.pitch                  = 1'b1;
          press_stack[press_depth] = n;
          press_depth++;
        end
      end
      OP_OFF: begin
        held_mask[n] = 1'b0;
        // Only a release of the top entry walks the stack.
        if (press_depth > 0 && press_stack[press_depth-1] == n) begin
          while (press_depth > 0 && !held_mask[press_stack[press_depth-1]])
            press_depth--;
          if (press_depth > 0) begin
            sounding_note = press_stack[press_depth-1];
            r.pitch       = 1'b1;
          end else begin
            r.gclose = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.note = sounding_note;
  endtask

  // Sends one message in bursts with random gaps, then predicts its result
  // once the beat is taken.
  task automatic send_msg(input logic [BYTE_W-1:0] st, input logic [BYTE_W-1:0] nt,
                          input logic [BYTE_W-1:0] vl);
    voice_result_t r;
    int unsigned   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      // Now and then a long stretch without any gap.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    status_byte <= st;
    note_number <= nt;
    velocity    <= vl;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    voice_predict(st, nt, vl, r);
    voice_due.push_back(r);
    msgs_sent++;
    if (press_depth > deepest) deepest = press_depth;
  endtask

  // Extremes of every field, each kind of message and each corner of the walk.
  task automatic test_directed_messages();
    send_msg(8'h00, 8'd0,   8'd0);
    send_msg(8'hFF, 8'hFF,  8'hFF);
    send_msg(8'hA0, 8'd60,  8'd100);
    send_msg(8'h90, 8'd128, 8'd100);
    send_msg(8'h80, 8'd255, 8'd0);
    // Note-off with nothing pressed.
    send_msg(8'h80, 8'd60,  8'd64);
    // First push opens the gate, a repeated top note is ignored.
    send_msg(8'h90, 8'd0,   8'd1);
    send_msg(8'h9F, 8'd0,   8'd127);
    send_msg(8'h93, 8'd127, 8'd255);
    send_msg(8'h91, 8'd64,  8'd80);
    // Release below the top, then a zero-velocity release of the top that
    // pops past the released note.
    send_msg(8'h80, 8'd127, 8'd0);
    send_msg(8'h90, 8'd64,  8'd0);
    send_msg(8'h8F, 8'd0,   8'd200);
    // Three pushes, the lower two released first, then the top closes the gate.
    send_msg(8'h92, 8'd100, 8'd50);
    send_msg(8'h90, 8'd101, 8'd50);
    send_msg(8'h90, 8'd102, 8'd50);
    send_msg(8'h80, 8'd101, 8'd10);
    send_msg(8'h80, 8'd100, 8'd10);
    send_msg(8'h80, 8'd102, 8'd0);
    // The same note twice in the stack, not adjacent.
    send_msg(8'h90, 8'd42,  8'h55);
    send_msg(8'h90, 8'd43,  8'hAA);
    send_msg(8'h90, 8'd42,  8'h7F);
    send_msg(8'h80, 8'd42,  8'd1);
    send_msg(8'h80, 8'd43,  8'd1);
    send_msg(8'hB0, 8'd10,  8'd10);
    send_msg(8'h70, 8'd10,  8'd10);
  endtask

  // Fills the stack, overflows it and releases the top so that the walk
  // crosses every entry.
  task automatic test_stack_full();
    int k;
    while (press_depth != 0)
      send_msg(STATUS_NOTE_OFF, {1'b0, press_stack[press_depth-1]}, 8'd0);
    for (k = 0; k < NOTE_DEPTH; k++)
      send_msg(STATUS_NOTE_ON, 8'(k), 8'($urandom_range(1, 255)));
    send_msg(STATUS_NOTE_ON, 8'd5, 8'd90);
    send_msg(STATUS_NOTE_ON, 8'(NOTE_DEPTH - 1), 8'd90);
    for (k = 1; k < NOTE_DEPTH - 1; k++)
      send_msg(STATUS_NOTE_OFF, 8'(k), 8'($urandom_range(0, 255)));
    send_msg(STATUS_NOTE_OFF, 8'(NOTE_DEPTH - 1), 8'd0);
    send_msg(STATUS_NOTE_OFF, 8'd0, 8'd0);
  endtask

  // Playing phrases on a small pool of notes, mixed with stray messages.
  task automatic test_random_phrases(input int count);
    int unsigned       pool_lo, pool_sz, pick;
    int                k;
    logic [3:0]        chan;
    logic [BYTE_W-1:0] st, nt, vl;
    pool_lo = 0;
    pool_sz = 4;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        pool_sz = $urandom_range(2, 12);
        pool_lo = $urandom_range(0, NOTE_COUNT - pool_sz);
      end
      chan = 4'($urandom_range(0, 15));
      nt   = 8'(pool_lo + $urandom_range(0, pool_sz - 1));
      vl   = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        st = STATUS_NOTE_ON | {4'h0, chan};
        vl = 8'($urandom_range(1, 255));
      end else if (pick < 66) begin
        st = STATUS_NOTE_OFF | {4'h0, chan};
      end else if (pick < 80) begin
        st = STATUS_NOTE_ON | {4'h0, chan};
        vl = 8'd0;
      end else if (pick < 88) begin
        // Release whatever sounds now.
        st = STATUS_NOTE_OFF | {4'h0, chan};
        if (press_depth > 0) nt = {1'b0, press_stack[press_depth-1]};
      end else if (pick < 94) begin
        st = 8'($urandom_range(0, 255));
        nt = 8'($urandom_range(0, 255));
      end else begin
        st = ($urandom_range(0, 1) ? STATUS_NOTE_ON : STATUS_NOTE_OFF) | {4'h0, chan};
        nt = 8'($urandom_range(NOTE_COUNT, 255));
      end
      send_msg(st, nt, vl);
    end
  endtask

  // Compares every result beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (voice_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: result beat with nothing pending: note=%0d pu=%0b go=%0b gc=%0b ov=%0b",
                   current_note, pitch_update, gate_open, gate_close, stack_overflow);
      end else begin
        voice_got = voice_due.pop_front();
        if (voice_got.note !== current_note || voice_got.pitch !== pitch_update ||
            voice_got.gopen !== gate_open || voice_got.gclose !== gate_close ||
            voice_got.ovf !== stack_overflow) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("ERROR: msg %02h/%02h/%02h: want note=%0d pu=%0b go=%0b gc=%0b ov=%0b, got note=%0d pu=%0b go=%0b gc=%0b ov=%0b",
                     voice_got.msg_status, voice_got.msg_note, voice_got.msg_velo,
                     voice_got.note, voice_got.pitch, voice_got.gopen, voice_got.gclose,
                     voice_got.ovf, current_note, pitch_update, gate_open, gate_close,
                     stack_overflow);
        end
        cnt_open  += gate_open;
        cnt_close += gate_close;
        cnt_pitch += pitch_update;
        cnt_ovf   += stack_overflow;
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("ERROR: no progress for %0d cycles", WATCHDOG_MAX);
      $display("** mono_note_priority_stack_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst           <= 1'b1;
    start         <= 1'b0;
    status_byte   <= '0;
    note_number   <= '0;
    velocity      <= '0;
    held_mask     = '0;
    press_depth   = 0;
    sounding_note = RESET_NOTE;
    burst_left    = 0;
    idle_cycles   = 0;
    errors        = 0;
    msgs_sent     = 0;
    results_seen  = 0;
    cnt_open      = 0;
    cnt_close     = 0;
    cnt_pitch     = 0;
    cnt_ovf       = 0;
    deepest       = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_messages();
    test_stack_full();
    test_random_phrases(RANDOM_ITEMS);

    start <= 1'b0;
    while (voice_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d messages, checked %0d results; deepest stack %0d.",
             msgs_sent, results_seen, deepest);
    $display("Seen %0d gate opens, %0d gate closes, %0d pitch updates, %0d overflows.",
             cnt_open, cnt_close, cnt_pitch, cnt_ovf);
    if (errors == 0) begin
      $display("** mono_note_priority_stack_top: PASSED **");
    end else begin
      $display("%0d mismatching or unexpected results", errors);
      $display("** mono_note_priority_stack_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== mono_note_priority_stack_top.f =====
hdl/mnps_pkg.sv
hdl/mnps_stack_mem.sv
hdl/mnps_held_flags.sv
hdl/mnps_seq.sv
hdl/mono_note_priority_stack_top.sv
sim/tb_mono_note_priority_stack_top.sv
